[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// Used by the trigger sequencer, the echo timer and the top level.
`timescale 1ns / 1ps

package uer_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CM_W        = 10;
	localparam int unsigned TIMEOUT_W   = 16;
	localparam int unsigned REM_W       = 6;
	localparam int unsigned TRIG_CNT_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_CM  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CM  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam logic [CM_W-1:0]      MIN_CM_RESET  = 10'd2;
	localparam logic [CM_W-1:0]      MAX_CM_RESET  = 10'd400;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;

	localparam logic [REM_W-1:0]      CM_DIVISOR      = 6'd58;
	localparam logic [TRIG_CNT_W-1:0] TRIG_LOW_TICKS  = 4'd2;
	localparam logic [TRIG_CNT_W-1:0] TRIG_HIGH_TICKS = 4'd10;

	typedef enum logic [1:0] {
		TRIG_IDLE = 2'd0,
		TRIG_LOW  = 2'd1,
		TRIG_HIGH = 2'd2
	} trig_phase_t;

	typedef struct packed {
		logic [CM_W-1:0]      min_cm;
		logic [CM_W-1:0]      max_cm;
		logic [TIMEOUT_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic            distance_valid;
		logic [CM_W-1:0] distance_cm;
		logic            timed_out;
	} range_result_t;

endpackage

[rtl/uer_trigger.sv]
// Trigger pulse sequencer: low for two ticks, then high for ten ticks.
// Depends on uer_pkg for the phase type and tick constants.
`timescale 1ns / 1ps

module uer_trigger import uer_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic start_request,
	output logic trigger_level
);

	trig_phase_t            phase_q, phase_d;
	logic [TRIG_CNT_W-1:0]  ticks_q, ticks_d;
	logic [TRIG_CNT_W-1:0]  ticks_inc;

	assign ticks_inc = ticks_q + 1'b1;

	always_comb begin
		phase_d       = phase_q;
		ticks_d       = ticks_q;
		trigger_level = 1'b0;
		unique case (phase_q)
			TRIG_LOW: begin
				if (ticks_inc >= TRIG_LOW_TICKS) begin
					phase_d = TRIG_HIGH;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			TRIG_HIGH: begin
				trigger_level = 1'b1;
				if (ticks_inc >= TRIG_HIGH_TICKS) begin
					phase_d = TRIG_IDLE;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			default: begin
				// A start takes its first low tick at once.
				phase_d = TRIG_IDLE;
				ticks_d = '0;
				if (start_request) begin
					phase_d = TRIG_LOW;
					ticks_d = 4'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TRIG_IDLE;
			ticks_q <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
		end
	end

endmodule

[rtl/uer_echo_timer.sv]
// Echo pulse timer with a running centimetre quotient, clamp and timeout.
// Depends on uer_pkg for the configuration and result structs.
`timescale 1ns / 1ps

module uer_echo_timer import uer_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick,
	input  logic          echo_level,
	input  cfg_t          cfg,
	output range_result_t result
);

	localparam int unsigned QUOT_W = COUNT_WIDTH - 5;
	localparam int unsigned CMP_W  = (QUOT_W > CM_W) ? QUOT_W : CM_W;
	localparam int unsigned TMO_W  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic                   echo_prev_q;
	logic                   waiting_q, waiting_d;
	logic [COUNT_WIDTH-1:0] pulse_q, pulse_d;
	logic [QUOT_W-1:0]      quot_q, quot_d;
	logic [REM_W-1:0]       rem_q, rem_d;
	logic                   rise, fall;
	logic [CMP_W-1:0]       cm_low, cm_clamped;

	assign rise = echo_level & ~echo_prev_q;
	assign fall = ~echo_level & echo_prev_q;

	// The quotient and remainder track pulse / 58 as the pulse count steps by one.
	always_comb begin
		waiting_d = waiting_q;
		pulse_d   = pulse_q;
		quot_d    = quot_q;
		rem_d     = rem_q;
		result    = '0;
		if (rise) begin
			waiting_d = 1'b1;
			pulse_d   = '0;
			quot_d    = '0;
			rem_d     = '0;
		end else if (waiting_q) begin
			if (pulse_q != COUNT_MAX) begin
				pulse_d = pulse_q + 1'b1;
				if (rem_q == CM_DIVISOR - 1'b1) begin
					rem_d  = '0;
					quot_d = quot_q + 1'b1;
				end else begin
					rem_d = rem_q + 1'b1;
				end
			end
			if (fall) begin
				waiting_d             = 1'b0;
				result.distance_valid = 1'b1;
				result.distance_cm    = cm_clamped[CM_W-1:0];
			end else if (TMO_W'(pulse_d) > TMO_W'(cfg.timeout)) begin
				waiting_d             = 1'b0;
				result.distance_valid = 1'b1;
				result.distance_cm    = cfg.max_cm;
				result.timed_out      = 1'b1;
			end
		end
	end

	always_comb begin
		cm_low     = (CMP_W'(quot_d) < CMP_W'(cfg.min_cm)) ? CMP_W'(cfg.min_cm) : CMP_W'(quot_d);
		cm_clamped = (cm_low > CMP_W'(cfg.max_cm)) ? CMP_W'(cfg.max_cm) : cm_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q <= 1'b0;
			waiting_q   <= 1'b0;
			pulse_q     <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
		end else if (tick) begin
			echo_prev_q <= echo_level;
			waiting_q   <= waiting_d;
			pulse_q     <= pulse_d;
			quot_q      <= quot_d;
			rem_q       <= rem_d;
		end
	end

endmodule

[rtl/ultrasonic_echo_ranger_top.sv]
// Ultrasonic echo ranger: one request per microsecond tick, one result per request.
// The result of an accepted request is registered in the output register.
// One request per cycle unless stalled; the output register holds a result while stalled.
// Asynchronous active-low reset clears the trigger sequencer, the echo timer and the
// output valid, and loads the registers with min 2 cm, max 400 cm and a 30000-tick timeout.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top import uer_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // echo_level, start_request
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // trigger_level, distance_cm
	output logic [1:0]             m_tuser,   // distance_valid, timed_out
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t          cfg_q;
	logic          accept;
	logic          trigger_level;
	range_result_t result;
	logic          m_tvalid_q;
	logic          trigger_q;
	range_result_t result_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~m_tvalid_q | m_tready;
	assign accept    = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_cm  <= MIN_CM_RESET;
			cfg_q.max_cm  <= MAX_CM_RESET;
			cfg_q.timeout <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_CM:  cfg_q.min_cm  <= cfg_data[CM_W-1:0];
				REG_MAX_CM:  cfg_q.max_cm  <= cfg_data[CM_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	uer_trigger u_trigger (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (accept),
		.start_request (s_tdata[1]),
		.trigger_level (trigger_level)
	);

	uer_echo_timer #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_echo_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (accept),
		.echo_level (s_tdata[0]),
		.cfg        (cfg_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trigger_q <= trigger_level;
			result_q  <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, result_q.distance_cm, trigger_q};
	assign m_tuser  = {result_q.timed_out, result_q.distance_valid};

endmodule
